FILE: src/mtk_pkg.sv
// mtk_pkg: shared types, command and status codes, segment encodings and the
// character code lookup of the text keyer. No dependencies.
`default_nettype none

package mtk_pkg;

    // one input transaction
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] text_char;
    } item_t;

    // one result transaction
    typedef struct packed {
        logic       key_on;
        logic       send_done;
        logic [1:0] status;
        logic [9:0] segments_stored;
    } result_t;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_START  = 2'd2;
    localparam logic [1:0] CMD_TICK   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_REFUSED = 2'd2;
    localparam logic [1:0] ST_BUSY    = 2'd3;

    // stored segment codes: +n mark, -n space, 4-bit two's complement
    localparam int SEG_W = 4;
    localparam logic [SEG_W-1:0] SEG_DOT    = 4'd1;
    localparam logic [SEG_W-1:0] SEG_DASH   = 4'd3;
    localparam logic [SEG_W-1:0] SEG_SPACE1 = 4'hF;
    localparam logic [SEG_W-1:0] SEG_SPACE3 = 4'hD;
    localparam logic [SEG_W-1:0] SEG_SPACE7 = 4'h9;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_GAP,
        S_MARK,
        S_SPACE,
        S_PLAY
    } state_t;

    // element pattern: first element in bit 5, 1 = dash
    typedef struct packed {
        logic       hit;
        logic [2:0] len;
        logic [5:0] pat;
    } code_t;

    function automatic code_t morse_lookup(input logic [7:0] ch);
        logic [7:0] uc;
        code_t      c;
        uc = ch;
        if (ch >= 8'h61 && ch <= 8'h7A)
        begin
            uc = ch - 8'd32;
        end
        c = '{hit: 1'b1, len: 3'd0, pat: 6'b000000};
        case (uc)
            "A": begin c.len = 3'd2; c.pat = 6'b010000; end
            "B": begin c.len = 3'd4; c.pat = 6'b100000; end
            "C": begin c.len = 3'd4; c.pat = 6'b101000; end
            "D": begin c.len = 3'd3; c.pat = 6'b100000; end
            "E": begin c.len = 3'd1; c.pat = 6'b000000; end
            "F": begin c.len = 3'd4; c.pat = 6'b001000; end
            "G": begin c.len = 3'd3; c.pat = 6'b110000; end
            "H": begin c.len = 3'd4; c.pat = 6'b000000; end
            "I": begin c.len = 3'd2; c.pat = 6'b000000; end
            "J": begin c.len = 3'd4; c.pat = 6'b011100; end
            "K": begin c.len = 3'd3; c.pat = 6'b101000; end
            "L": begin c.len = 3'd4; c.pat = 6'b010000; end
            "M": begin c.len = 3'd2; c.pat = 6'b110000; end
            "N": begin c.len = 3'd2; c.pat = 6'b100000; end
            "O": begin c.len = 3'd3; c.pat = 6'b111000; end
            "P": begin c.len = 3'd4; c.pat = 6'b011000; end
            "Q": begin c.len = 3'd4; c.pat = 6'b110100; end
            "R": begin c.len = 3'd3; c.pat = 6'b010000; end
            "S": begin c.len = 3'd3; c.pat = 6'b000000; end
            "T": begin c.len = 3'd1; c.pat = 6'b100000; end
            "U": begin c.len = 3'd3; c.pat = 6'b001000; end
            "V": begin c.len = 3'd4; c.pat = 6'b000100; end
            "W": begin c.len = 3'd3; c.pat = 6'b011000; end
            "X": begin c.len = 3'd4; c.pat = 6'b100100; end
            "Y": begin c.len = 3'd4; c.pat = 6'b101100; end
            "Z": begin c.len = 3'd4; c.pat = 6'b110000; end
            "0": begin c.len = 3'd5; c.pat = 6'b111110; end
            "1": begin c.len = 3'd5; c.pat = 6'b011110; end
            "2": begin c.len = 3'd5; c.pat = 6'b001110; end
            "3": begin c.len = 3'd5; c.pat = 6'b000110; end
            "4": begin c.len = 3'd5; c.pat = 6'b000010; end
            "5": begin c.len = 3'd5; c.pat = 6'b000000; end
            "6": begin c.len = 3'd5; c.pat = 6'b100000; end
            "7": begin c.len = 3'd5; c.pat = 6'b110000; end
            "8": begin c.len = 3'd5; c.pat = 6'b111000; end
            "9": begin c.len = 3'd5; c.pat = 6'b111100; end
            "/": begin c.len = 3'd5; c.pat = 6'b100100; end
            "?": begin c.len = 3'd6; c.pat = 6'b001100; end
            ".": begin c.len = 3'd6; c.pat = 6'b010101; end
            ",": begin c.len = 3'd6; c.pat = 6'b110011; end
            "-": begin c.len = 3'd6; c.pat = 6'b100001; end
            "+": begin c.len = 3'd5; c.pat = 6'b010100; end
            "=": begin c.len = 3'd5; c.pat = 6'b100010; end
            default: c.hit = 1'b0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: src/mtk_ram.sv
// mtk_ram: generic single-write, single-read memory with registered read data.
// No dependencies.
`default_nettype none

module mtk_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: src/morse_text_keyer.sv
// morse_text_keyer: top level of the text keyer, sequencer, segment counters
// and playback. Depends on mtk_pkg and mtk_ram.
`default_nettype none

//  channel  | signals                          | direction | carries
//  ---------+----------------------------------+-----------+-------------------------
//  item     | item_valid, item_stall, item     | in        | cmd, text_char
//  result   | result_valid, result_stall, result | out     | key_on, send_done,
//           |                                  |           | status, segments_stored
//
// one transaction is handled at a time; the sequencer writes one segment per
// cycle through the single store write port, so an append is a decode step
// followed by up to 12 segment writes (gap plus six elements and five element
// spaces); a tick is decoded and, if it reads a new segment from the store,
// goes on to a play step. clear and start end in decode. rst_n is asynchronous
// and clears all control state; the segment store itself is not cleared, only
// entries below the count are ever read. the result register holds a finished
// result until it is taken; the next item waits while result_stall holds it.

module morse_text_keyer
    import mtk_pkg::*;
#(
    parameter int MAX_SEGMENTS = 512
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    output logic         item_stall,
    input  wire item_t   item,
    output logic         result_valid,
    input  wire logic    result_stall,
    output result_t      result
);

    localparam int AW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_SEGMENTS);

    // control state
    state_t        state_reg, state_next;
    logic [CW-1:0] len_reg, len_next;       // segments in the store
    logic [CW-1:0] pos_reg, pos_next;       // playback position
    logic [2:0]    units_reg, units_next;   // units left in current segment
    logic          key_reg, key_next;       // level of current segment
    logic          gap7_reg, gap7_next;     // word gap armed
    logic          send_reg, send_next;     // sending active
    logic          ovf_reg, ovf_next;       // sticky overflow
    logic          out_valid_reg, out_valid_next;

    // transaction and working registers
    logic [1:0]    cmd_reg, cmd_next;
    logic [7:0]    char_reg, char_next;
    logic [5:0]    pat_reg, pat_next;       // remaining elements, next in bit 5
    logic [2:0]    left_reg, left_next;     // elements still to write
    result_t       out_reg, out_next;

    // store port
    logic             ram_we;
    logic [SEG_W-1:0] ram_wdata;
    logic             ram_re;
    logic [SEG_W-1:0] ram_rdata;

    // shared decisions
    logic          accept;
    logic          full;
    logic          pos_end;
    logic          is_space;
    code_t         code;
    logic          finish;
    logic          res_key;
    logic          res_done;
    logic [1:0]    res_status;
    logic [2:0]    seg_units;
    logic [CW+9:0] len_ext;

    assign accept   = item_valid & ~item_stall;
    assign full     = (len_reg >= MAX_COUNT);
    assign pos_end  = (pos_reg >= len_reg);
    assign is_space = (char_reg == CHAR_SPACE) || (char_reg == CHAR_TAB);
    assign code     = morse_lookup(char_reg);

    // a stored space is negative, its length is the negated code
    assign seg_units = ram_rdata[SEG_W-1] ? 3'(4'd0 - ram_rdata) : ram_rdata[2:0];

    // busy while a transaction is in work, or when the result slot stays taken
    assign item_stall   = (state_reg != S_IDLE) | (out_valid_reg & result_stall);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // a transaction completes on the step back to idle
    assign finish = (state_reg != S_IDLE) && (state_next == S_IDLE);

    mtk_ram #(
        .WIDTH (SEG_W),
        .DEPTH (MAX_SEGMENTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (len_reg[AW-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (pos_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (cmd_reg)
                    CMD_APPEND:
                    begin
                        if (!send_reg && !ovf_reg && !is_space && code.hit)
                        begin
                            state_next = (len_reg != '0) ? S_GAP : S_MARK;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    CMD_TICK:
                    begin
                        if (send_reg && units_reg == 3'd0 && !pos_end)
                        begin
                            state_next = S_PLAY;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    CMD_CLEAR,
                    CMD_START:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_GAP:
            begin
                state_next = full ? S_IDLE : S_MARK;
            end
            S_MARK:
            begin
                state_next = (full || left_reg == 3'd1) ? S_IDLE : S_SPACE;
            end
            S_SPACE:
            begin
                state_next = full ? S_IDLE : S_MARK;
            end
            S_PLAY:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and result
    always_comb
    begin
        len_next   = len_reg;
        pos_next   = pos_reg;
        units_next = units_reg;
        key_next   = key_reg;
        gap7_next  = gap7_reg;
        send_next  = send_reg;
        ovf_next   = ovf_reg;
        pat_next   = pat_reg;
        left_next  = left_reg;
        cmd_next   = cmd_reg;
        char_next  = char_reg;
        ram_we     = 1'b0;
        ram_wdata  = SEG_SPACE1;
        ram_re     = 1'b0;
        res_key    = 1'b0;
        res_done   = 1'b0;
        res_status = ST_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next  = item.cmd;
                    char_next = item.text_char;
                end
            end
            S_DECODE:
            begin
                unique case (cmd_reg)
                    CMD_CLEAR:
                    begin
                        len_next   = '0;
                        pos_next   = '0;
                        units_next = 3'd0;
                        key_next   = 1'b0;
                        gap7_next  = 1'b0;
                        send_next  = 1'b0;
                        ovf_next   = 1'b0;
                    end
                    CMD_APPEND:
                    begin
                        if (send_reg)
                        begin
                            res_status = ST_BUSY;
                        end
                        else if (ovf_reg)
                        begin
                            res_status = ST_FULL;
                        end
                        else if (is_space)
                        begin
                            // word gap only after something is stored
                            if (len_reg != '0)
                            begin
                                gap7_next = 1'b1;
                            end
                        end
                        else if (code.hit)
                        begin
                            pat_next  = code.pat;
                            left_next = code.len;
                        end
                    end
                    CMD_START:
                    begin
                        if (send_reg)
                        begin
                            res_status = ST_BUSY;
                        end
                        else if (len_reg == '0 || ovf_reg)
                        begin
                            res_status = ST_REFUSED;
                        end
                        else
                        begin
                            send_next  = 1'b1;
                            pos_next   = '0;
                            units_next = 3'd0;
                            key_next   = 1'b0;
                        end
                    end
                    CMD_TICK:
                    begin
                        if (send_reg)
                        begin
                            if (units_reg != 3'd0)
                            begin
                                res_key    = key_reg;
                                units_next = units_reg - 3'd1;
                                res_status = ST_BUSY;
                            end
                            else if (pos_end)
                            begin
                                send_next = 1'b0;
                                res_done  = 1'b1;
                            end
                            else
                            begin
                                ram_re = 1'b1;
                            end
                        end
                    end
                endcase
            end
            S_GAP:
            begin
                if (full)
                begin
                    ovf_next   = 1'b1;
                    res_status = ST_FULL;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_wdata = gap7_reg ? SEG_SPACE7 : SEG_SPACE3;
                    len_next  = len_reg + 1'b1;
                    gap7_next = 1'b0;
                end
            end
            S_MARK:
            begin
                if (full)
                begin
                    ovf_next   = 1'b1;
                    res_status = ST_FULL;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_wdata = pat_reg[5] ? SEG_DASH : SEG_DOT;
                    len_next  = len_reg + 1'b1;
                end
            end
            S_SPACE:
            begin
                if (full)
                begin
                    ovf_next   = 1'b1;
                    res_status = ST_FULL;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_wdata = SEG_SPACE1;
                    len_next  = len_reg + 1'b1;
                    pat_next  = {pat_reg[4:0], 1'b0};
                    left_next = left_reg - 3'd1;
                end
            end
            S_PLAY:
            begin
                // first unit of a new segment
                pos_next   = pos_reg + 1'b1;
                key_next   = ~ram_rdata[SEG_W-1];
                units_next = seg_units - 3'd1;
                res_key    = ~ram_rdata[SEG_W-1];
                res_status = ST_BUSY;
            end
            default:
            begin
                res_status = ST_OK;
            end
        endcase
    end

    // count after the step, low 10 bits
    assign len_ext = {{10{1'b0}}, len_next};

    // result slot
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg & result_stall;
        if (finish)
        begin
            out_valid_next           = 1'b1;
            out_next.key_on          = res_key;
            out_next.send_done       = res_done;
            out_next.status          = res_status;
            out_next.segments_stored = len_ext[9:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            pos_reg       <= '0;
            units_reg     <= 3'd0;
            key_reg       <= 1'b0;
            gap7_reg      <= 1'b0;
            send_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            pos_reg       <= pos_next;
            units_reg     <= units_next;
            key_reg       <= key_next;
            gap7_reg      <= gap7_next;
            send_reg      <= send_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        char_reg <= char_next;
        pat_reg  <= pat_next;
        left_reg <= left_next;
        out_reg  <= out_next;
    end

endmodule

`default_nettype wire

FILE: bench/tb_morse_text_keyer.sv
// tb_morse_text_keyer: self-checking testbench of the morse text keyer, with a
// behavioral predictor, a queue-fed driver and a result monitor.
// Depends on mtk_pkg and morse_text_keyer.
`default_nettype none

module tb_morse_text_keyer;
    import mtk_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SEG     = 512;
    localparam int LIMIT       = 600000;  // cycles before the run is declared hung
    localparam int HOLD_CYCLES = 240;     // long receiver hold-off
    localparam int TAIL_CYCLES = 20;      // settle time after the last result
    localparam int TICK_CHUNK  = 6;       // ticks queued per playback step

    // characters in the code book, upper case
    localparam string CHARSET = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789/?.,-+=";
    // long codes, used to overrun the store quickly
    localparam string LONGSET = "0123456789?.,-";

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    morse_text_keyer #(
        .MAX_SEGMENTS(MAX_SEG)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // keyer predictor: shadow copy of the segment store and playback state
    // ------------------------------------------------------------------
    logic [SEG_W-1:0] seg_mem [MAX_SEG];
    int unsigned      seq_len;
    int unsigned      play_pos;
    logic [2:0]       units_left;
    logic [2:0]       word_gap;
    logic             cur_key;
    logic             tx_active;
    logic             ovf_flag;

    // dot/dash spelling of a character, empty when it has no code
    function automatic string morse_spelling(logic [7:0] ch);
        logic [7:0] uc;
        uc = ch;
        if (ch >= "a" && ch <= "z")
        begin
            uc = ch - 8'd32;
        end
        case (uc)
            "A": return ".-";      "B": return "-...";    "C": return "-.-.";
            "D": return "-..";     "E": return ".";       "F": return "..-.";
            "G": return "--.";     "H": return "....";    "I": return "..";
            "J": return ".---";    "K": return "-.-";     "L": return ".-..";
            "M": return "--";      "N": return "-.";      "O": return "---";
            "P": return ".--.";    "Q": return "--.-";    "R": return ".-.";
            "S": return "...";     "T": return "-";       "U": return "..-";
            "V": return "...-";    "W": return ".--";     "X": return "-..-";
            "Y": return "-.--";    "Z": return "--..";
            "0": return "-----";   "1": return ".----";   "2": return "..---";
            "3": return "...--";   "4": return "....-";   "5": return ".....";
            "6": return "-....";   "7": return "--...";   "8": return "---..";
            "9": return "----.";
            "/": return "-..-.";   "?": return "..--..";  ".": return ".-.-.-";
            ",": return "--..--";  "-": return "-....-";  "+": return ".-.-.";
            "=": return "-...-";
            default: return "";
        endcase
    endfunction

    // store one mark or space; a full store sets the sticky overflow
    function automatic bit store_segment(bit mark, logic [2:0] units);
        if (seq_len >= MAX_SEG)
        begin
            ovf_flag = 1'b1;
            return 1'b0;
        end
        seg_mem[seq_len] = mark ? {1'b0, units} : 4'(16 - int'(units));
        seq_len++;
        return 1'b1;
    endfunction

    function automatic logic [1:0] append_char(logic [7:0] ch);
        string code;
        if (tx_active)
            return ST_BUSY;
        if (ovf_flag)
            return ST_FULL;
        if (ch == CHAR_SPACE || ch == CHAR_TAB)
        begin
            // word gap armed only behind something already stored
            if (seq_len > 0 && word_gap < 3'd7)
                word_gap = 3'd7;
            return ST_OK;
        end
        code = morse_spelling(ch);
        if (code.len() == 0)
            return ST_OK;
        if (seq_len > 0)
        begin
            if (!store_segment(1'b0, (word_gap != 3'd0) ? word_gap : 3'd3))
                return ST_FULL;
        end
        word_gap = 3'd0;
        for (int p = 0; p < code.len(); p++)
        begin
            if (!store_segment(1'b1, (code[p] == "-") ? 3'd3 : 3'd1))
                return ST_FULL;
            if (p + 1 < code.len() && !store_segment(1'b0, 3'd1))
                return ST_FULL;
        end
        return ST_OK;
    endfunction

    // expected result of one transaction, state updated in place
    function automatic result_t keyer_step(item_t it);
        result_t    r;
        logic [3:0] seg;
        r = '0;
        case (it.cmd)
            CMD_CLEAR:
            begin
                seq_len    = 0;
                play_pos   = 0;
                units_left = '0;
                cur_key    = 1'b0;
                word_gap   = '0;
                tx_active  = 1'b0;
                ovf_flag   = 1'b0;
            end
            CMD_APPEND:
            begin
                r.status = append_char(it.text_char);
            end
            CMD_START:
            begin
                if (tx_active)
                    r.status = ST_BUSY;
                else if (seq_len == 0 || ovf_flag)
                    r.status = ST_REFUSED;
                else
                begin
                    tx_active  = 1'b1;
                    play_pos   = 0;
                    units_left = '0;
                    cur_key    = 1'b0;
                end
            end
            default:
            begin
                if (tx_active)
                begin
                    if (units_left == 3'd0 && (play_pos >= seq_len || play_pos >= MAX_SEG))
                    begin
                        tx_active   = 1'b0;
                        r.send_done = 1'b1;
                    end
                    else
                    begin
                        if (units_left == 3'd0)
                        begin
                            seg = seg_mem[play_pos];
                            play_pos++;
                            if (seg[3])
                            begin
                                cur_key    = 1'b0;
                                units_left = 3'(16 - int'(seg));
                            end
                            else
                            begin
                                cur_key    = 1'b1;
                                units_left = seg[2:0];
                            end
                        end
                        r.key_on   = cur_key;
                        units_left = units_left - 3'd1;
                        r.status   = ST_BUSY;
                    end
                end
            end
        endcase
        r.segments_stored = 10'(seq_len);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // bookkeeping shared by the driver, the monitor and the sequence
    // ------------------------------------------------------------------
    item_t   pending_items [$];   // transactions not yet offered
    result_t keyed_results [$];   // predicted results, oldest first
    int      n_queued   = 0;
    int      n_accepted = 0;
    int      err_count  = 0;
    int      cycle_count = 0;
    logic    item_taken = 1'b0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      holds_asked = 0;
    int      holds_done  = 0;
    int      hold_left   = 0;

    task automatic report_mismatch(string what, int got, int want);
        if (err_count < 40)
            $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        err_count++;
    endtask

    // driver: a new transaction is put up at the falling edge once the
    // previous one was accepted, or after an idle cycle
    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || item_taken))
        begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                item       <= pending_items.pop_front();
                item_valid <= 1'b1;
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, or a long hold-off when one was asked for
    always @(negedge clk)
    begin
        if (holds_done < holds_asked)
        begin
            hold_left    <= HOLD_CYCLES;
            holds_done   <= holds_done + 1;
            result_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // monitor: check the accepted result, then predict the accepted item;
    // a result never belongs to an item accepted on the same edge
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            item_taken <= item_valid && !item_stall;
            if (result_valid && !result_stall)
            begin
                if (keyed_results.size() == 0)
                begin
                    report_mismatch("unexpected result, status", result.status, 0);
                end
                else
                begin
                    want = keyed_results.pop_front();
                    if (result.key_on !== want.key_on)
                        report_mismatch("key_on", result.key_on, want.key_on);
                    if (result.send_done !== want.send_done)
                        report_mismatch("send_done", result.send_done, want.send_done);
                    if (result.status !== want.status)
                        report_mismatch("status", result.status, want.status);
                    if (result.segments_stored !== want.segments_stored)
                        report_mismatch("segments_stored", result.segments_stored,
                                        want.segments_stored);
                end
            end
            if (item_valid && !item_stall)
            begin
                keyed_results.push_back(keyer_step(item));
                n_accepted++;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic send(logic [1:0] cmd, logic [7:0] ch);
        item_t it;
        it.cmd       = cmd;
        it.text_char = ch;
        pending_items.push_back(it);
        n_queued++;
    endtask

    // wait until every queued transaction has been accepted
    task automatic wait_accepted();
        while (n_accepted != n_queued)
            @(posedge clk);
    endtask

    // sender pause: nothing in flight and nothing expected
    task automatic wait_quiet();
        wait_accepted();
        while (keyed_results.size() != 0)
            @(posedge clk);
    endtask

    // tick until the predictor says playback has ended
    task automatic play_out();
        wait_accepted();
        while (tx_active)
        begin
            repeat (TICK_CHUNK) send(CMD_TICK, 8'($urandom_range(255)));
            wait_accepted();
        end
    endtask

    function automatic logic [7:0] pick_char();
        int         r;
        logic [7:0] c;
        r = $urandom_range(99);
        if (r < 72)
        begin
            c = CHARSET[$urandom_range(CHARSET.len() - 1)];
            // fold check: letters sometimes in lower case
            if (c >= "A" && c <= "Z" && $urandom_range(1))
                c = c + 8'd32;
        end
        else if (r < 84)
            c = CHAR_SPACE;
        else if (r < 90)
            c = CHAR_TAB;
        else
            c = 8'($urandom_range(255));
        return c;
    endfunction

    // fill the store past its end, then poke at it while overflowed
    task automatic overrun_store(bit with_hold);
        send(CMD_CLEAR, 8'($urandom_range(255)));
        if (with_hold)
            holds_asked++;
        repeat (55 + $urandom_range(8))
            send(CMD_APPEND, LONGSET[$urandom_range(LONGSET.len() - 1)]);
        send(CMD_START, 8'($urandom_range(255)));
        send(CMD_APPEND, pick_char());
        send(CMD_APPEND, CHAR_SPACE);
        send(CMD_TICK, 8'($urandom_range(255)));
        send(CMD_CLEAR, 8'($urandom_range(255)));
    endtask

    // a short message: clear (most of the time), text, start, play to the end
    task automatic send_message();
        if ($urandom_range(99) < 85)
            send(CMD_CLEAR, 8'($urandom_range(255)));
        repeat (1 + $urandom_range(4))
            send(CMD_APPEND, pick_char());
        send(CMD_START, 8'($urandom_range(255)));
        case ($urandom_range(9))
            0: send(CMD_APPEND, pick_char());          // append while sending
            1: send(CMD_START, 8'($urandom_range(255))); // start while sending
            2:
            begin
                // abort in mid-play
                repeat (1 + $urandom_range(8)) send(CMD_TICK, 8'($urandom_range(255)));
                send(CMD_CLEAR, 8'($urandom_range(255)));
            end
            default: ;
        endcase
        play_out();
        repeat ($urandom_range(2)) send(CMD_TICK, 8'($urandom_range(255)));
    endtask

    task automatic random_phase(int stop_at);
        int r;
        overrun_store(1'b1);
        while (n_queued < stop_at)
        begin
            r = $urandom_range(99);
            if (r < 80)
                send_message();
            else if (r < 86)
                overrun_store(1'b0);
            else
            begin
                // noise: anything the fields allow
                repeat (1 + $urandom_range(5))
                    send(2'($urandom_range(3)), 8'($urandom_range(255)));
                play_out();
            end
        end
        wait_quiet();
    endtask

    initial
    begin
        seq_len    = 0;
        play_pos   = 0;
        units_left = '0;
        word_gap   = '0;
        cur_key    = 1'b0;
        tx_active  = 1'b0;
        ovf_flag   = 1'b0;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 17;
        recv_idle_pct = 54;

        // directed: idle tick, empty start, case fold, tab word gap, dash,
        // unknown characters at both ends of the byte, busy refusals, play
        send(CMD_TICK, 8'h00);
        send(CMD_START, 8'hFF);
        send(CMD_APPEND, CHAR_TAB);     // nothing stored yet, no gap armed
        send(CMD_APPEND, "a");
        send(CMD_APPEND, CHAR_TAB);
        send(CMD_APPEND, 8'hFF);
        send(CMD_APPEND, 8'h00);
        send(CMD_APPEND, "T");
        send(CMD_START, 8'h00);
        send(CMD_START, 8'h00);
        send(CMD_APPEND, "E");
        play_out();
        send(CMD_TICK, 8'hFF);
        send(CMD_CLEAR, 8'hFF);
        wait_quiet();

        random_phase(480);

        send_idle_pct = 54;
        recv_idle_pct = 17;
        random_phase(960);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(1450);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0 && keyed_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
src/mtk_pkg.sv
src/mtk_ram.sv
src/morse_text_keyer.sv
bench/tb_morse_text_keyer.sv
